// ===== rtl/thermistor_adc_to_temperature_top_macros.svh =====
// assertion macros used by the port-level checker
// no dependencies
`ifndef THERMISTOR_ADC_TO_TEMPERATURE_TOP_MACROS_SVH
`define THERMISTOR_ADC_TO_TEMPERATURE_TOP_MACROS_SVH

// checked only outside reset
`define THADC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge
`define THADC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/thadc_pkg.sv =====
// constants and types of the thermistor conversion pipeline
// no dependencies
package thadc_pkg;

   localparam logic [9:0]  CODE_MAX  = 10'd1023;
   localparam logic [27:0] CLN_Q40   = 28'd178274476;
   localparam logic [33:0] K0_Q40    = 34'd3687780070;
   localparam logic [60:0] TERM_RND  = 61'd134217728;
   localparam logic [62:0] HK_NUM    = 63'(100) << 56;
   localparam logic [39:0] C_OFF     = 40'd1790115840;
   localparam logic [39:0] F_OFF     = 40'd3012493312;
   localparam logic [39:0] Y_BIAS    = 40'd6553927680;
   localparam logic [15:0] RECIP10   = 16'd52429;
   localparam logic [14:0] TEN_K     = 15'd10000;
   localparam logic [13:0] ABS0_F    = 14'h2E0B;
   localparam logic [13:0] ABS0_C    = 14'h3554;

   typedef struct packed {
      logic valid;
      logic celsius;
      logic fault;
   } ctl_type;

endpackage

// ===== rtl/thermistor_adc_to_temperature_top.sv =====
// thermistor divider code to temperature in tenths of a degree, beta equation
// depends on thadc_pkg
// throughput: one transaction per cycle while rsp is not stalled, from one squaring multiplier per log2 fraction bit
//    and one subtract per quotient bit of the kelvin reciprocal
// backpressure on rsp freezes the whole pipeline, nothing is lost or repeated
// reset (synchronous) clears all stage valid bits and selects fahrenheit
module thermistor_adc_to_temperature_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_wdata,     // scale_select
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,     // adc_code[9:0], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,     // temperature_tenths[13:0], zero fill
   output logic        rsp_tuser      // sensor_fault
);
   import thadc_pkg::*;

   localparam int LOG_N  = 28;
   localparam int S_DIFF = LOG_N + 1;
   localparam int S_MUL  = S_DIFF + 1;
   localparam int S_INV  = S_MUL + 1;
   localparam int S_DIV0 = S_INV + 1;
   localparam int DIV_N  = 34;
   localparam int S_P9   = S_DIV0 + DIV_N + 1;
   localparam int D5_N   = 5;
   localparam int S_Y    = S_P9 + D5_N + 1;
   localparam int S_T    = S_Y + 1;
   localparam int S_OUT  = S_T + 1;
   localparam int N_STG  = S_OUT + 1;

   logic    adv;
   logic    scale_ff;
   ctl_type ctl_in;
   ctl_type ctl_ff [0:N_STG-1];
   logic [9:0] code;

   function automatic logic [3:0] top_bit(input logic [9:0] x);
      logic [3:0] k;
      k = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (x[i]) begin
            k = 4'(i);
         end
      end
      return k;
   endfunction

   assign adv        = rsp_tready || !rsp_tvalid;
   assign req_tready = adv;
   assign code       = req_tdata[9:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= 1'b0;
      end else if (csr_we) begin
         scale_ff <= csr_wdata;
      end
   end

   always_comb begin
      ctl_in.valid   = req_tvalid;
      ctl_in.celsius = scale_ff;
      ctl_in.fault   = (code == 10'd0) || (code == CODE_MAX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < N_STG; s++) begin
            ctl_ff[s] <= '0;
         end
      end else if (adv) begin
         ctl_ff[0] <= ctl_in;
         for (int s = 1; s < N_STG; s++) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
      end
   end

   // log2 lanes: lane 0 is 1023 - code, lane 1 is code
   logic [30:0] lm_ff [0:LOG_N][0:1];
   logic [27:0] lf_ff [0:LOG_N][0:1];
   logic [3:0]  lk_ff [0:LOG_N][0:1];

   for (genvar l = 0; l < 2; l++) begin : g_enc
      logic [9:0]  x;
      logic [3:0]  k_in;
      logic [30:0] m_in;
      assign x    = (l == 0) ? (CODE_MAX - code) : code;
      assign k_in = top_bit(x);
      assign m_in = 31'(x) << (5'd30 - {1'b0, k_in});
      always_ff @(posedge clock) begin
         if (adv) begin
            lm_ff[0][l] <= m_in;
            lf_ff[0][l] <= '0;
            lk_ff[0][l] <= k_in;
         end
      end
   end

   for (genvar j = 1; j <= LOG_N; j++) begin : g_log
      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [61:0] sq;
         logic [31:0] sh;
         logic [30:0] m_in;
         logic [27:0] f_in;
         assign sq   = 62'(lm_ff[j-1][l]) * 62'(lm_ff[j-1][l]);
         assign sh   = sq[61:30];
         assign m_in = sh[31] ? sh[31:1] : sh[30:0];
         assign f_in = {lf_ff[j-1][l][26:0], sh[31]};
         always_ff @(posedge clock) begin
            if (adv) begin
               lm_ff[j][l] <= m_in;
               lf_ff[j][l] <= f_in;
               lk_ff[j][l] <= lk_ff[j-1][l];
            end
         end
      end
   end

   // log ratio magnitude and sign
   logic [31:0] la, lb, mag_in, mag_ff;
   logic        neg_in, neg_ff, neg2_ff;
   assign la     = {lk_ff[LOG_N][0], lf_ff[LOG_N][0]};
   assign lb     = {lk_ff[LOG_N][1], lf_ff[LOG_N][1]};
   assign neg_in = la < lb;
   assign mag_in = neg_in ? (lb - la) : (la - lb);

   logic [59:0] prod_in, prod_ff;
   assign prod_in = 60'(mag_ff) * 60'(CLN_Q40);

   logic [60:0] term_sum;
   logic [33:0] inv_sum;
   logic [32:0] inv_in, inv_ff;
   assign term_sum = 61'(prod_ff) + TERM_RND;
   assign inv_sum  = neg2_ff ? (K0_Q40 - 34'(term_sum[60:28]))
                             : (K0_Q40 + 34'(term_sum[60:28]));
   assign inv_in   = inv_sum[32:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff  <= mag_in;
         neg_ff  <= neg_in;
         prod_ff <= prod_in;
         neg2_ff <= neg_ff;
         inv_ff  <= inv_in;
      end
   end

   // restoring division for kelvin, one quotient bit per stage
   logic [62:0] dr_ff [0:DIV_N];
   logic [32:0] dd_ff [0:DIV_N];
   logic [33:0] dq_ff [0:DIV_N];
   logic [62:0] dr0_in;
   assign dr0_in = HK_NUM + 63'(inv_ff[32:1]);

   always_ff @(posedge clock) begin
      if (adv) begin
         dr_ff[0] <= dr0_in;
         dd_ff[0] <= inv_ff;
         dq_ff[0] <= '0;
      end
   end

   for (genvar i = 1; i <= DIV_N; i++) begin : g_div
      localparam int B = DIV_N - i;
      logic [66:0] sd, rr;
      logic        ge;
      logic [62:0] r_in;
      logic [33:0] q_in;
      assign sd   = 67'(dd_ff[i-1]) << B;
      assign rr   = 67'(dr_ff[i-1]);
      assign ge   = rr >= sd;
      assign r_in = ge ? 63'(rr - sd) : dr_ff[i-1];
      always_comb begin
         q_in    = dq_ff[i-1];
         q_in[B] = ge;
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dr_ff[i] <= r_in;
            dd_ff[i] <= dd_ff[i-1];
            dq_ff[i] <= q_in;
         end
      end
   end

   // fahrenheit path: hk*9 then divide by 5, eight bits per stage
   logic [39:0] p9_ff [0:D5_N];
   logic [33:0] hk_ff [0:D5_N];
   logic [39:0] fq_ff [0:D5_N];
   logic [2:0]  fr_ff [0:D5_N];
   logic [39:0] p9_in;
   assign p9_in = (40'(dq_ff[DIV_N]) << 3) + 40'(dq_ff[DIV_N]);

   always_ff @(posedge clock) begin
      if (adv) begin
         p9_ff[0] <= p9_in;
         hk_ff[0] <= dq_ff[DIV_N];
         fq_ff[0] <= '0;
         fr_ff[0] <= '0;
      end
   end

   for (genvar g = 1; g <= D5_N; g++) begin : g_div5
      localparam int HI = 39 - 8 * (g - 1);
      logic [2:0]  r_in;
      logic [7:0]  qb;
      always_comb begin
         logic [3:0] t;
         r_in = fr_ff[g-1];
         qb   = '0;
         for (int s = 0; s < 8; s++) begin
            t = {r_in, p9_ff[g-1][HI-s]};
            if (t >= 4'd5) begin
               qb[7-s] = 1'b1;
               r_in    = 3'(t - 4'd5);
            end else begin
               r_in    = t[2:0];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            p9_ff[g] <= p9_ff[g-1];
            hk_ff[g] <= hk_ff[g-1];
            fq_ff[g] <= {fq_ff[g-1][31:0], qb};
            fr_ff[g] <= r_in;
         end
      end
   end

   // scale, offset and round to tenths
   logic        sel_c;
   logic [39:0] y;
   logic [17:0] z_in, z_ff;
   assign sel_c = ctl_ff[S_Y-1].celsius;
   assign y     = (sel_c ? 40'(hk_ff[D5_N]) : fq_ff[D5_N]) + Y_BIAS - (sel_c ? C_OFF : F_OFF);
   assign z_in  = y[33:16];

   logic [33:0] tp;
   logic [14:0] t_in, t_ff;
   assign tp   = 34'(z_ff) * 34'(RECIP10);
   assign t_in = tp[33:19];

   logic [14:0] t_off;
   logic [13:0] temp_in, temp_ff;
   assign t_off   = t_ff - TEN_K;
   assign temp_in = ctl_ff[S_OUT-1].fault ? (ctl_ff[S_OUT-1].celsius ? ABS0_C : ABS0_F)
                                          : t_off[13:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         z_ff    <= z_in;
         t_ff    <= t_in;
         temp_ff <= temp_in;
      end
   end

   assign rsp_tvalid = ctl_ff[N_STG-1].valid;
   assign rsp_tuser  = ctl_ff[N_STG-1].fault;
   assign rsp_tdata  = {2'b00, temp_ff};

endmodule

// ===== rtl/thadc_checker.sv =====
// port-level checks for the thermistor conversion top level, with its bind
// depends on thermistor_adc_to_temperature_top_macros.svh
`include "thermistor_adc_to_temperature_top_macros.svh"

module thadc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);

   `THADC_ASSERT(a_fault_abs_zero, rsp_tvalid && rsp_tuser |-> (rsp_tdata[13:0] == 14'h2E0B || rsp_tdata[13:0] == 14'h3554), "fault transaction without absolute zero")
   `THADC_ASSERT(a_pad_zero, rsp_tvalid |-> rsp_tdata[15:14] == 2'b00, "nonzero fill in rsp_tdata")
   `THADC_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled rsp transaction changed")
   `THADC_ASSERT_ALWAYS(a_ready_when_empty, !rsp_tvalid |-> req_tready, "req stalled with empty output")

endmodule

bind thermistor_adc_to_temperature_top thadc_checker u_thadc_checker (.*);

// ===== tb/sv/thermistor_adc_to_temperature_top_tb.sv =====
// testbench for thermistor_adc_to_temperature_top: converter codes to temperature
// depends on thadc_pkg and the top level rtl; self-checking with a bit-exact predictor
module thermistor_adc_to_temperature_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import thadc_pkg::*;

   localparam int LATENCY     = 76;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [13:0] tenths;
      logic        fault;
   } reading_type;

   // fixed-point log2 of a 10-bit integer, Q28
   function automatic logic [63:0] log2_fixed(input logic [9:0] x);
      int unsigned top;
      logic [63:0] mant;
      logic [63:0] frac;
      top = 0;
      frac = 0;
      if (x == 0) return 0;
      for (int b = 0; b < 10; b++) if (x[b]) top = b;
      mant = 64'(x) << (30 - top);
      for (int i = 0; i < 28; i++) begin
         mant = (mant * mant) >> 30;
         frac = frac << 1;
         if (mant >= (64'd1 << 31)) begin
            frac[0] = 1'b1;
            mant = mant >> 1;
         end
      end
      return (64'(top) << 28) | frac;
   endfunction

   function automatic reading_type predict_reading(input logic [9:0] code, input logic celsius);
      reading_type r;
      logic [63:0] la, lb, mag, term, inv, hk, y;
      logic signed [63:0] x;
      r.fault = (code == 0 || code == CODE_MAX);
      if (r.fault) begin
         r.tenths = celsius ? ABS0_C : ABS0_F;
         return r;
      end
      la = log2_fixed(CODE_MAX - code);
      lb = log2_fixed(code);
      mag = (la >= lb) ? la - lb : lb - la;
      term = (mag * 64'd178274476 + (64'd1 << 27)) >> 28;
      inv = (la >= lb) ? 64'd3687780070 + term : 64'd3687780070 - term;
      if (inv == 0) inv = 1;
      hk = ((64'd100 << 56) + inv / 2) / inv;
      if (celsius) x = $signed(hk) - 64'sd27315 * 65536;
      else x = $signed((hk * 9) / 5) - 64'sd45967 * 65536;
      y = 64'(x + 64'sd6553600000) + 64'd5 * 65536;
      r.tenths = 14'((y / 655360) - 10000);
      return r;
   endfunction

   class reading_scoreboard;
      reading_type pending[$];
      int errors;
      function void note_code(logic [9:0] code, logic celsius);
         pending.push_back(predict_reading(code, celsius));
      endfunction
      function void check_reading(logic [13:0] tenths, logic fault);
         reading_type e;
         if (pending.size() == 0) begin
            $display("%0t unexpected transaction: tenths %0d fault %0b", $time,
               $signed(tenths), fault);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (e.tenths !== tenths) begin
            $display("%0t tenths expected %0d actual %0d", $time, $signed(e.tenths),
               $signed(tenths));
            errors++;
         end
         if (e.fault !== fault) begin
            $display("%0t fault expected %0b actual %0b", $time, e.fault, fault);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic        csr_wdata = 0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;

   reading_scoreboard board = new();
   logic scale = 0;
   logic rsp_done = 0;
   int   cycles = 0;

   thermistor_adc_to_temperature_top dut (.*);

   initial forever #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("thermistor_adc_to_temperature_top: mismatch");
         $finish;
      end
   end

   always @(posedge clock) if (!reset && rsp_tvalid && rsp_tready)
      board.check_reading(rsp_tdata[13:0], rsp_tuser);

   function automatic int gap_len();
      if ($urandom_range(0, 3) == 0) return 0;
      return ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
   endfunction

   // random receiver stall pattern, rsp_tready redrawn at every clock
   initial begin
      int g;
      while (!rsp_done) begin
         @(posedge clock);
         if ($urandom_range(0, 99) < 30) rsp_tready <= 1;
         else begin
            g = gap_len();
            rsp_tready <= (g == 0);
         end
      end
   end

   // valid stays high across back-to-back transactions
   task automatic send_code(input logic [9:0] code, input bit may_idle);
      int g;
      g = may_idle ? gap_len() : 0;
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {6'd0, code};
      do @(posedge clock); while (!req_tready);
      board.note_code(code, scale);
   endtask

   task automatic set_scale(input logic celsius);
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1;
      csr_wdata <= celsius;
      @(posedge clock);
      csr_we <= 0;
      scale = celsius;
   endtask

   initial begin
      logic [9:0] edges[$] = '{0, 1, 2, 3, 511, 512, 513, 1020, 1021, 1022, 1023, 10'h155,
                               10'h2AA, 300, 700, 100, 900};
      logic [9:0] c;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int p = 0; p < 4; p++) begin
         if (p > 0) set_scale(p[0]);
         foreach (edges[i]) send_code(edges[i], p[1]);
         for (int i = 0; i < 300; i++) begin
            case ($urandom_range(0, 9))
               0: c = $urandom_range(0, 1) ? 10'd0 : 10'd1023;
               1: c = 10'($urandom_range(0, 1) ? $urandom_range(1, 8)
                                                : $urandom_range(1015, 1022));
               default: c = 10'($urandom_range(0, 1023));
            endcase
            send_code(c, 1);
         end
      end
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      rsp_done = 1;
      if (board.errors == 0 && board.pending.size() == 0)
         $display("thermistor_adc_to_temperature_top: match");
      else
         $display("thermistor_adc_to_temperature_top: mismatch");
      $finish;
   end
endmodule

// ===== thermistor_adc_to_temperature_top.f =====
+incdir+rtl
rtl/thadc_pkg.sv
rtl/thermistor_adc_to_temperature_top.sv
rtl/thadc_checker.sv
tb/sv/thermistor_adc_to_temperature_top_tb.sv
